// File: hw/rtl/i2ctcs_pkg.sv
// ----------------------------------------------------------------------------
// i2ctcs_pkg
// shared types and codes for the i2c transfer chunk sequencer
// ----------------------------------------------------------------------------
package i2ctcs_pkg;

   localparam int unsigned ADDR_BITS  = 10;
   localparam int unsigned COUNT_BITS = 8;
   localparam int unsigned KIND_BITS  = 3;
   localparam int unsigned MODE_BITS  = 2;

   // event codes on the request channel
   localparam logic [MODE_BITS-1:0] MODE_START    = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_COMPLETE = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_RELOAD   = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_ERROR    = 2'd3;

   // transfer kinds
   localparam logic [KIND_BITS-1:0] KIND_TX         = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_RX         = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_TX_DOUBLE  = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_RX_DOUBLE  = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_WRITE_READ = 3'd4;

   typedef enum logic [2:0] {
      EVT_START,
      EVT_COMPLETE,
      EVT_RELOAD,
      EVT_ERROR,
      EVT_IGNORE
   } evt_type;

   // classified command passed from front to back
   typedef struct packed {
      evt_type               evt;
      logic [KIND_BITS-1:0]  kind;
      logic                  is_read;
      logic                  is_double;
   } cmd_type;

   // one result transaction
   typedef struct packed {
      logic                  control_write;
      logic [ADDR_BITS-1:0]  target_address;
      logic [COUNT_BITS-1:0] byte_count;
      logic                  reload_flag;
      logic                  read_not_write;
      logic                  send_start;
      logic                  send_stop;
      logic                  switch_buffer;
      logic                  done_res;
      logic                  error_flag;
   } rsp_type;

endpackage

// File: hw/rtl/i2ctcs_front.sv
// ----------------------------------------------------------------------------
// i2ctcs_front
// decodes an incoming transaction into a command for the sequencer back end
// ----------------------------------------------------------------------------
module i2ctcs_front
   import i2ctcs_pkg::*;
(
   input  logic [MODE_BITS-1:0] mode,
   input  logic [KIND_BITS-1:0] kind,
   output cmd_type              cmd
);

   always_comb begin
      cmd.kind      = kind;
      cmd.is_read   = (kind == KIND_RX) || (kind == KIND_RX_DOUBLE);
      cmd.is_double = (kind == KIND_TX_DOUBLE) || (kind == KIND_RX_DOUBLE);
      unique case (mode)
         MODE_START: begin
            if (kind > KIND_WRITE_READ) begin
               cmd.evt = EVT_IGNORE;
            end else begin
               cmd.evt = EVT_START;
            end
         end
         MODE_COMPLETE: cmd.evt = EVT_COMPLETE;
         MODE_RELOAD:   cmd.evt = EVT_RELOAD;
         MODE_ERROR:    cmd.evt = EVT_ERROR;
         default:       cmd.evt = EVT_IGNORE;
      endcase
   end

endmodule

// File: hw/rtl/i2ctcs_queue.sv
// ----------------------------------------------------------------------------
// i2ctcs_queue
// two-entry queue between the front and back ends
// ----------------------------------------------------------------------------
module i2ctcs_queue #(
   parameter int unsigned WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// File: hw/rtl/i2ctcs_back.sv
// ----------------------------------------------------------------------------
// i2ctcs_back
// transfer state, chunk counting and the registered result stage
// ----------------------------------------------------------------------------
module i2ctcs_back
   import i2ctcs_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = 16,
   parameter int unsigned CHUNK_MAX   = 255
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   input  cmd_type                cmd,
   input  logic [ADDR_BITS-1:0]   cmd_address,
   input  logic [LENGTH_BITS-1:0] cmd_first,
   input  logic [LENGTH_BITS-1:0] cmd_second,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp
);

   localparam logic [LENGTH_BITS-1:0] CHUNK_LIMIT = LENGTH_BITS'(CHUNK_MAX);

   logic [KIND_BITS-1:0]   kind_ff,  kind_in;
   logic                   busy_ff,  busy_in;
   logic                   rd_ff,    rd_in;
   logic [LENGTH_BITS-1:0] tx_ff,    tx_in;
   logic [LENGTH_BITS-1:0] rx_ff,    rx_in;
   logic [LENGTH_BITS-1:0] sb_ff,    sb_in;
   logic [ADDR_BITS-1:0]   addr_ff,  addr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff,   rsp_in;
   logic                   pop;

   // shared chunk unit
   logic [LENGTH_BITS-1:0] chunk_src;
   logic [LENGTH_BITS-1:0] chunk_n;
   logic [LENGTH_BITS-1:0] chunk_rest;

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign pop       = cmd_valid && cmd_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      chunk_src = tx_ff;
      unique case (cmd.evt)
         EVT_START:    chunk_src = cmd_first;
         EVT_COMPLETE: chunk_src = rx_ff;
         EVT_RELOAD: begin
            if (rd_ff) begin
               chunk_src = rx_ff;
            end else begin
               chunk_src = tx_ff;
            end
            if ((chunk_src == '0) && (sb_ff != '0)) begin
               chunk_src = sb_ff;
            end
         end
         default:      chunk_src = tx_ff;
      endcase
      chunk_n    = (chunk_src > CHUNK_LIMIT) ? CHUNK_LIMIT : chunk_src;
      chunk_rest = chunk_src - chunk_n;
   end

   always_comb begin
      kind_in = kind_ff;
      busy_in = busy_ff;
      rd_in   = rd_ff;
      tx_in   = tx_ff;
      rx_in   = rx_ff;
      sb_in   = sb_ff;
      addr_in = addr_ff;
      rsp_in  = '0;
      unique case (cmd.evt)
         EVT_START: begin
            kind_in = cmd.kind;
            busy_in = 1'b1;
            addr_in = cmd_address;
            rd_in   = cmd.is_read;
            sb_in   = cmd.is_double ? cmd_second : '0;
            tx_in   = '0;
            rx_in   = (cmd.kind == KIND_WRITE_READ) ? cmd_second : '0;
            if (cmd.is_read) begin
               rx_in = chunk_rest;
            end else begin
               tx_in = chunk_rest;
            end
            rsp_in.control_write  = 1'b1;
            rsp_in.byte_count     = chunk_n[COUNT_BITS-1:0];
            rsp_in.reload_flag    = (chunk_rest != '0) || (sb_in != '0);
            rsp_in.read_not_write = cmd.is_read;
            rsp_in.send_start     = 1'b1;
         end
         EVT_COMPLETE: begin
            if (busy_ff) begin
               if ((kind_ff == KIND_WRITE_READ) && (rx_ff != '0)) begin
                  rx_in   = chunk_rest;
                  kind_in = KIND_RX;
                  rd_in   = 1'b1;
                  rsp_in.control_write  = 1'b1;
                  rsp_in.byte_count     = chunk_n[COUNT_BITS-1:0];
                  rsp_in.reload_flag    = (chunk_rest != '0);
                  rsp_in.read_not_write = 1'b1;
                  rsp_in.send_start     = 1'b1;
               end else begin
                  busy_in          = 1'b0;
                  rsp_in.send_stop = 1'b1;
                  rsp_in.done_res  = 1'b1;
               end
            end
         end
         EVT_RELOAD: begin
            if (busy_ff) begin
               if ((rd_ff ? rx_ff : tx_ff) == '0 && (sb_ff != '0)) begin
                  sb_in                = '0;
                  rsp_in.switch_buffer = 1'b1;
               end
               if (rd_ff) begin
                  rx_in = chunk_rest;
               end else begin
                  tx_in = chunk_rest;
               end
               rsp_in.control_write  = 1'b1;
               rsp_in.byte_count     = chunk_n[COUNT_BITS-1:0];
               rsp_in.reload_flag    = (chunk_rest != '0) || (sb_in != '0);
               rsp_in.read_not_write = rd_ff;
            end
         end
         EVT_ERROR: begin
            if (busy_ff) begin
               busy_in           = 1'b0;
               rsp_in.send_stop  = 1'b1;
               rsp_in.done_res   = 1'b1;
               rsp_in.error_flag = 1'b1;
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
      rsp_in.target_address = addr_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= '0;
         busy_ff      <= 1'b0;
         rd_ff        <= 1'b0;
         tx_ff        <= '0;
         rx_ff        <= '0;
         sb_ff        <= '0;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            kind_ff <= kind_in;
            busy_ff <= busy_in;
            rd_ff   <= rd_in;
            tx_ff   <= tx_in;
            rx_ff   <= rx_in;
            sb_ff   <= sb_in;
            addr_ff <= addr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: hw/rtl/i2c_transfer_chunk_sequencer_unit.sv
// ----------------------------------------------------------------------------
// i2c_transfer_chunk_sequencer_unit
// splits i2c master transfers into chunks of at most CHUNK_MAX bytes
//
//   channel  direction  handshake              contents
//   req_     in         req_valid / req_ready  event, kind, address, lengths
//   rsp_     out        rsp_valid / rsp_ready  control word and status flags
//
// one transaction per cycle sustained while rsp_ready holds; a result is registered
// in the back end's result stage after its request has passed through the queue
// the front decoder and back sequencer are parted by a two-entry queue, so up
// to two requests are still taken while a result waits on rsp_ready
// synchronous active-high reset clears all transfer state and empties the queue
// ----------------------------------------------------------------------------
module i2c_transfer_chunk_sequencer_unit
   import i2ctcs_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = 16,
   parameter int unsigned CHUNK_MAX   = 255
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [MODE_BITS-1:0]   req_mode,
   input  logic [KIND_BITS-1:0]   req_transfer_kind,
   input  logic [ADDR_BITS-1:0]   req_device_address,
   input  logic [LENGTH_BITS-1:0] req_first_length,
   input  logic [LENGTH_BITS-1:0] req_second_length,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_control_write,
   output logic [ADDR_BITS-1:0]   rsp_target_address,
   output logic [COUNT_BITS-1:0]  rsp_byte_count,
   output logic                   rsp_reload_flag,
   output logic                   rsp_read_not_write,
   output logic                   rsp_send_start,
   output logic                   rsp_send_stop,
   output logic                   rsp_switch_buffer,
   output logic                   rsp_done_res,
   output logic                   rsp_error_flag
);

   localparam int unsigned QW = $bits(cmd_type) + ADDR_BITS + 2 * LENGTH_BITS;

   cmd_type                front_cmd;
   cmd_type                back_cmd;
   logic [QW-1:0]          q_in_data;
   logic [QW-1:0]          q_out_data;
   logic                   q_out_valid;
   logic                   q_out_ready;
   logic [ADDR_BITS-1:0]   back_address;
   logic [LENGTH_BITS-1:0] back_first;
   logic [LENGTH_BITS-1:0] back_second;
   rsp_type                rsp;

   i2ctcs_front u_front (
      .mode (req_mode),
      .kind (req_transfer_kind),
      .cmd  (front_cmd)
   );

   assign q_in_data = {front_cmd, req_device_address, req_first_length, req_second_length};

   i2ctcs_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (q_in_data),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready),
      .out_data  (q_out_data)
   );

   assign {back_cmd, back_address, back_first, back_second} = q_out_data;

   i2ctcs_back #(
      .LENGTH_BITS (LENGTH_BITS),
      .CHUNK_MAX   (CHUNK_MAX)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (q_out_valid),
      .cmd_ready   (q_out_ready),
      .cmd         (back_cmd),
      .cmd_address (back_address),
      .cmd_first   (back_first),
      .cmd_second  (back_second),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp         (rsp)
   );

   assign rsp_control_write  = rsp.control_write;
   assign rsp_target_address = rsp.target_address;
   assign rsp_byte_count     = rsp.byte_count;
   assign rsp_reload_flag    = rsp.reload_flag;
   assign rsp_read_not_write = rsp.read_not_write;
   assign rsp_send_start     = rsp.send_start;
   assign rsp_send_stop      = rsp.send_stop;
   assign rsp_switch_buffer  = rsp.switch_buffer;
   assign rsp_done_res       = rsp.done_res;
   assign rsp_error_flag     = rsp.error_flag;

endmodule

// File: tb/sv/i2c_transfer_chunk_sequencer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_transfer_chunk_sequencer_unit_tb
// self-checking bench for the i2c transfer chunk sequencer
//
// a short table of directed events covers idle events, unknown kinds,
// empty and full-length transfers, buffer switching, the write-then-read
// turnaround and bus errors. Rows with an obvious answer carry it typed in;
// the rest are checked against a local model of the sequencer. About two
// thousand random events follow, mostly whole transfers (start, reloads,
// complete or error) mixed with loose events. Both channels idle in random
// bursts, the result side is held off once for a long stretch so the unit
// backs up, and every result transaction is compared field by field in order.
// ----------------------------------------------------------------------------
module i2c_transfer_chunk_sequencer_unit_tb;
   import i2ctcs_pkg::*;

   localparam int unsigned LEN_W       = 16;
   localparam int unsigned CHUNK_LIMIT = 255;
   localparam int unsigned RANDOM_ITEMS = 2000;
   localparam int unsigned CALM_TAIL   = 300;
   localparam int unsigned HOLD_CYCLES = 300;

   typedef struct {
      logic [MODE_BITS-1:0] mode;
      logic [KIND_BITS-1:0] kind;
      logic [ADDR_BITS-1:0] addr;
      logic [LEN_W-1:0]     first;
      logic [LEN_W-1:0]     second;
      bit                   typed;
      rsp_type              want;
   } event_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [MODE_BITS-1:0]  req_mode;
   logic [KIND_BITS-1:0]  req_transfer_kind;
   logic [ADDR_BITS-1:0]  req_device_address;
   logic [LEN_W-1:0]      req_first_length;
   logic [LEN_W-1:0]      req_second_length;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_control_write;
   logic [ADDR_BITS-1:0]  rsp_target_address;
   logic [COUNT_BITS-1:0] rsp_byte_count;
   logic                  rsp_reload_flag;
   logic                  rsp_read_not_write;
   logic                  rsp_send_start;
   logic                  rsp_send_stop;
   logic                  rsp_switch_buffer;
   logic                  rsp_done_res;
   logic                  rsp_error_flag;

   // sequencer model state
   logic [KIND_BITS-1:0] m_kind;
   bit                   m_busy;
   bit                   m_read;
   logic [LEN_W-1:0]     m_tx_left;
   logic [LEN_W-1:0]     m_rx_left;
   logic [LEN_W-1:0]     m_second_buf;
   logic [ADDR_BITS-1:0] m_addr;

   rsp_type       pending_words[$];
   event_row_type event_table[$];

   int unsigned n_fail;
   int unsigned n_live;
   int unsigned n_checked;
   int unsigned n_chunks;
   int unsigned n_switches;
   int unsigned n_bus_errors;
   bit          send_gaps;
   bit          sink_gaps;
   bit          hold_req;

   i2c_transfer_chunk_sequencer_unit #(
      .LENGTH_BITS(LEN_W),
      .CHUNK_MAX  (CHUNK_LIMIT)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_transfer_kind (req_transfer_kind),
      .req_device_address(req_device_address),
      .req_first_length  (req_first_length),
      .req_second_length (req_second_length),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_control_write (rsp_control_write),
      .rsp_target_address(rsp_target_address),
      .rsp_byte_count    (rsp_byte_count),
      .rsp_reload_flag   (rsp_reload_flag),
      .rsp_read_not_write(rsp_read_not_write),
      .rsp_send_start    (rsp_send_start),
      .rsp_send_stop     (rsp_send_stop),
      .rsp_switch_buffer (rsp_switch_buffer),
      .rsp_done_res      (rsp_done_res),
      .rsp_error_flag    (rsp_error_flag)
   );

   initial begin
      clock = 1'b0;
      forever begin
         #6 clock = ~clock;
      end
   end

   initial begin
      #(5_000_000);
      $display("i2c_transfer_chunk_sequencer_unit_tb NOT OK");
      $finish;
   end

   function automatic logic [COUNT_BITS-1:0] chunk_size(input logic [LEN_W-1:0] left);
      return (left > LEN_W'(CHUNK_LIMIT)) ? COUNT_BITS'(CHUNK_LIMIT)
                                          : left[COUNT_BITS-1:0];
   endfunction

   // advances the model by one event and returns the control word it causes
   function automatic rsp_type next_chunk_word(input logic [MODE_BITS-1:0] mode,
                                               input logic [KIND_BITS-1:0] kind,
                                               input logic [ADDR_BITS-1:0] addr,
                                               input logic [LEN_W-1:0] first,
                                               input logic [LEN_W-1:0] second);
      rsp_type                w;
      logic [COUNT_BITS-1:0]  cnt;
      logic [LEN_W-1:0]       left;
      bit                     is_read;
      bit                     is_double;
      w = '0;
      is_read   = (kind == KIND_RX) || (kind == KIND_RX_DOUBLE);
      is_double = (kind == KIND_TX_DOUBLE) || (kind == KIND_RX_DOUBLE);
      if (mode == MODE_START) begin
         if (kind <= KIND_WRITE_READ) begin
            m_kind       = kind;
            m_busy       = 1'b1;
            m_addr       = addr;
            m_read       = is_read;
            m_second_buf = is_double ? second : '0;
            cnt  = chunk_size(first);
            left = first - LEN_W'(cnt);
            if (is_read) begin
               m_rx_left = left;
               m_tx_left = '0;
            end else begin
               m_tx_left = left;
               m_rx_left = (kind == KIND_WRITE_READ) ? second : '0;
            end
            w.control_write  = 1'b1;
            w.byte_count     = cnt;
            w.reload_flag    = (left != 0) || (m_second_buf != 0);
            w.read_not_write = is_read;
            w.send_start     = 1'b1;
         end
      end else if (m_busy) begin
         case (mode)
            MODE_COMPLETE: begin
               if (m_kind == KIND_WRITE_READ && m_rx_left != 0) begin
                  // turnaround to the read phase with a repeated start
                  cnt        = chunk_size(m_rx_left);
                  m_rx_left  = m_rx_left - LEN_W'(cnt);
                  m_kind     = KIND_RX;
                  m_read     = 1'b1;
                  w.control_write  = 1'b1;
                  w.byte_count     = cnt;
                  w.reload_flag    = (m_rx_left != 0);
                  w.read_not_write = 1'b1;
                  w.send_start     = 1'b1;
               end else begin
                  m_busy     = 1'b0;
                  w.send_stop = 1'b1;
                  w.done_res  = 1'b1;
               end
            end
            MODE_RELOAD: begin
               left = m_read ? m_rx_left : m_tx_left;
               if (left == 0 && m_second_buf != 0) begin
                  left         = m_second_buf;
                  m_second_buf = '0;
                  w.switch_buffer = 1'b1;
               end
               cnt  = chunk_size(left);
               left = left - LEN_W'(cnt);
               if (m_read) begin
                  m_rx_left = left;
               end else begin
                  m_tx_left = left;
               end
               w.control_write  = 1'b1;
               w.byte_count     = cnt;
               w.reload_flag    = (left != 0) || (m_second_buf != 0);
               w.read_not_write = m_read;
            end
            MODE_ERROR: begin
               m_busy       = 1'b0;
               w.send_stop  = 1'b1;
               w.done_res   = 1'b1;
               w.error_flag = 1'b1;
            end
            default: begin
               w = '0;
            end
         endcase
      end
      w.target_address = m_addr;
      return w;
   endfunction

   function automatic rsp_type word(input bit cw, input logic [ADDR_BITS-1:0] addr,
                                    input logic [COUNT_BITS-1:0] cnt, input bit rl,
                                    input bit rnw, input bit st, input bit sp,
                                    input bit sw, input bit dn, input bit er);
      rsp_type w;
      w.control_write  = cw;
      w.target_address = addr;
      w.byte_count     = cnt;
      w.reload_flag    = rl;
      w.read_not_write = rnw;
      w.send_start     = st;
      w.send_stop      = sp;
      w.switch_buffer  = sw;
      w.done_res       = dn;
      w.error_flag     = er;
      return w;
   endfunction

   function automatic void add_row(input logic [MODE_BITS-1:0] mode,
                                   input logic [KIND_BITS-1:0] kind,
                                   input logic [ADDR_BITS-1:0] addr,
                                   input logic [LEN_W-1:0] first,
                                   input logic [LEN_W-1:0] second,
                                   input bit typed, input rsp_type want);
      event_row_type r;
      r.mode   = mode;
      r.kind   = kind;
      r.addr   = addr;
      r.first  = first;
      r.second = second;
      r.typed  = typed;
      r.want   = want;
      event_table.push_back(r);
   endfunction

   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      $display("mismatch in %s at transaction %0d: got %0h, want %0h",
               what, n_checked, got, want);
      n_fail++;
   endtask

   task automatic check_field(input string what, input int unsigned got,
                              input int unsigned want);
      if (got != want) begin
         flag_mismatch(what, got, want);
      end
   endtask

   // offers one event, waits until it is accepted and records the expected word
   task automatic send_event(input event_row_type r);
      rsp_type pred;
      @(negedge clock);
      if (send_gaps && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_valid          = 1'b1;
      req_mode           = r.mode;
      req_transfer_kind  = r.kind;
      req_device_address = r.addr;
      req_first_length   = r.first;
      req_second_length  = r.second;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      pred = next_chunk_word(r.mode, r.kind, r.addr, r.first, r.second);
      pending_words.push_back(r.typed ? r.want : pred);
      if (pred.control_write || pred.done_res) begin
         n_live++;
      end
   endtask

   task automatic send_random(input logic [MODE_BITS-1:0] mode,
                              input logic [KIND_BITS-1:0] kind);
      event_row_type r;
      r.mode   = mode;
      r.kind   = kind;
      r.addr   = ADDR_BITS'($urandom);
      r.first  = LEN_W'($urandom);
      r.second = LEN_W'($urandom);
      r.typed  = 1'b0;
      r.want   = '0;
      send_event(r);
   endtask

   function automatic logic [LEN_W-1:0] pick_length();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return LEN_W'($urandom);
         2: return LEN_W'($urandom_range(254, 256));
         3: return '1;
         default: return LEN_W'($urandom_range(1, 700));
      endcase
   endfunction

   // one well-formed transfer: start, a few reloads, then complete or error, and again if still busy
   task automatic random_transfer();
      event_row_type r;
      r.mode   = MODE_START;
      r.kind   = KIND_BITS'($urandom_range(0, 4));
      r.addr   = ADDR_BITS'($urandom);
      r.first  = pick_length();
      r.second = pick_length();
      r.typed  = 1'b0;
      r.want   = '0;
      send_event(r);
      repeat ($urandom_range(0, 6)) send_random(MODE_RELOAD, KIND_BITS'($urandom));
      send_random(($urandom_range(0, 7) == 0) ? MODE_ERROR : MODE_COMPLETE,
                  KIND_BITS'($urandom));
      if (m_busy) begin
         repeat ($urandom_range(0, 5)) send_random(MODE_RELOAD, KIND_BITS'($urandom));
         send_random(($urandom_range(0, 7) == 0) ? MODE_ERROR : MODE_COMPLETE,
                     KIND_BITS'($urandom));
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      wait (pending_words.size() == 0);
   endtask

   // result side: random stalls and the long hold-off
   initial begin
      int unsigned hold_left;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_ready = 1'b0;
            hold_left = HOLD_CYCLES;
            while (hold_left != 0) begin
               @(negedge clock);
               hold_left--;
            end
            hold_req  = 1'b0;
            rsp_ready = 1'b1;
         end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
            rsp_ready = 1'b1;
         end else begin
            rsp_ready = !reset;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_control_write, rsp_target_address, rsp_byte_count, rsp_reload_flag,
                rsp_read_not_write, rsp_send_start, rsp_send_stop, rsp_switch_buffer,
                rsp_done_res, rsp_error_flag};
         if (pending_words.size() == 0) begin
            flag_mismatch("unexpected result", 32'(got), 0);
         end else begin
            want = pending_words.pop_front();
            check_field("control_write", 32'(got.control_write), 32'(want.control_write));
            check_field("target_address", 32'(got.target_address),
                        32'(want.target_address));
            check_field("byte_count", 32'(got.byte_count), 32'(want.byte_count));
            check_field("reload_flag", 32'(got.reload_flag), 32'(want.reload_flag));
            check_field("read_not_write", 32'(got.read_not_write),
                        32'(want.read_not_write));
            check_field("send_start", 32'(got.send_start), 32'(want.send_start));
            check_field("send_stop", 32'(got.send_stop), 32'(want.send_stop));
            check_field("switch_buffer", 32'(got.switch_buffer), 32'(want.switch_buffer));
            check_field("done_res", 32'(got.done_res), 32'(want.done_res));
            check_field("error_flag", 32'(got.error_flag), 32'(want.error_flag));
         end
         n_checked++;
         n_chunks     += 32'(got.control_write);
         n_switches   += 32'(got.switch_buffer);
         n_bus_errors += 32'(got.error_flag);
      end
   end

   initial begin
      int unsigned live_goal;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_mode           = MODE_START;
      req_transfer_kind  = KIND_TX;
      req_device_address = '0;
      req_first_length   = '0;
      req_second_length  = '0;
      m_kind = KIND_TX;
      m_busy = 1'b0;
      m_read = 1'b0;
      m_tx_left = '0;
      m_rx_left = '0;
      m_second_buf = '0;
      m_addr = '0;
      n_fail = 0;
      n_live = 0;
      n_checked = 0;
      n_chunks = 0;
      n_switches = 0;
      n_bus_errors = 0;
      send_gaps = 1'b1;
      sink_gaps = 1'b1;
      hold_req  = 1'b0;

      // idle events and unknown kinds leave only the address showing
      add_row(MODE_COMPLETE, KIND_TX, '1, '1, '1, 1, word(0, '0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(MODE_RELOAD, KIND_TX, '1, '1, '1, 1, word(0, '0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(MODE_ERROR, KIND_TX, '1, '1, '1, 1, word(0, '0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(MODE_START, 3'd5, '1, '1, '1, 1, word(0, '0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(MODE_START, 3'd7, '1, '1, '1, 1, word(0, '0, 0, 0, 0, 0, 0, 0, 0, 0));
      // empty transmit, reload with nothing left, then complete
      add_row(MODE_START, KIND_TX, '1, '0, '1, 1, word(1, '1, 0, 0, 0, 1, 0, 0, 0, 0));
      add_row(MODE_RELOAD, KIND_TX, '0, '0, '0, 1, word(1, '1, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(MODE_COMPLETE, KIND_TX, '0, '0, '0, 1, word(0, '1, 0, 0, 0, 0, 1, 0, 1, 0));
      // longest receive, stopped early by complete
      add_row(MODE_START, KIND_RX, '0, '1, '1, 1, word(1, '0, 8'hFF, 1, 1, 1, 0, 0, 0, 0));
      add_row(MODE_RELOAD, KIND_RX, '1, '1, '1, 0, '0);
      add_row(MODE_COMPLETE, KIND_RX, '1, '1, '1, 1, word(0, '0, 0, 0, 0, 0, 1, 0, 1, 0));
      // double transmit moving to the second buffer, ended by a bus error
      add_row(MODE_START, KIND_TX_DOUBLE, 10'h155, 16'd3, 16'd300, 0, '0);
      add_row(MODE_RELOAD, KIND_TX, '0, '0, '0, 0, '0);
      add_row(MODE_RELOAD, KIND_TX, '0, '0, '0, 0, '0);
      add_row(MODE_RELOAD, KIND_TX, '0, '0, '0, 0, '0);
      add_row(MODE_ERROR, KIND_TX, '0, '0, '0, 1, word(0, 10'h155, 0, 0, 0, 0, 1, 0, 1, 1));
      // double receive with an empty first buffer, replaced by a new start
      add_row(MODE_START, KIND_RX_DOUBLE, 10'h2AA, 16'd0, 16'd10, 0, '0);
      add_row(MODE_RELOAD, KIND_TX, '0, '0, '0, 0, '0);
      add_row(MODE_START, KIND_WRITE_READ, 10'h001, 16'd2, 16'd256, 0, '0);
      add_row(MODE_COMPLETE, KIND_TX, '0, '0, '0, 0, '0);
      add_row(MODE_RELOAD, KIND_TX, '0, '0, '0, 0, '0);
      add_row(MODE_COMPLETE, KIND_TX, '0, '0, '0, 0, '0);
      // write-then-read with an empty read phase just stops
      add_row(MODE_START, KIND_WRITE_READ, 10'h200, 16'd5, 16'd0, 0, '0);
      add_row(MODE_COMPLETE, KIND_TX, '0, '0, '0, 1, word(0, 10'h200, 0, 0, 0, 0, 1, 0, 1, 0));
      add_row(MODE_ERROR, KIND_TX, '0, '0, '0, 1, word(0, 10'h200, 0, 0, 0, 0, 0, 0, 0, 0));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (event_table[i]) begin
         send_event(event_table[i]);
      end
      drain();

      // back-pressure: hold the result side while events keep coming
      hold_req  = 1'b1;
      send_gaps = 1'b0;
      repeat (4) random_transfer();
      drain();
      send_gaps = 1'b1;

      live_goal = n_live + RANDOM_ITEMS;
      while (n_live < live_goal) begin
         if ($urandom_range(0, 15) == 0) begin
            send_gaps = ($urandom_range(0, 2) != 0);
            sink_gaps = ($urandom_range(0, 2) != 0);
         end
         if (live_goal - n_live < CALM_TAIL) begin
            send_gaps = 1'b0;
            sink_gaps = 1'b0;
         end
         if ($urandom_range(0, 9) < 8) begin
            random_transfer();
         end else begin
            send_random(MODE_BITS'($urandom), KIND_BITS'($urandom));
         end
      end
      drain();
      repeat (8) @(posedge clock);

      $display("%0d result transactions checked: %0d chunk words, %0d buffer switches,",
               n_checked, n_chunks, n_switches);
      $display("%0d bus-error stops, one long result hold-off", n_bus_errors);
      if (n_fail == 0 && pending_words.size() == 0) begin
         $display("i2c_transfer_chunk_sequencer_unit_tb OK");
      end else begin
         $display("i2c_transfer_chunk_sequencer_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
